// ===== rtl/met_pkg.sv =====
// shared widths, constants and register indexes of the escape-time unit
package met_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int ITER_WIDTH_DEF  = 16;

    // internal coordinates are q4.28, operands carry one more integer bit
    localparam int WORK_FRAC = 28;
    localparam int INT_BITS  = 4;
    localparam int CQ_W      = WORK_FRAC + INT_BITS;
    localparam int OP_W      = CQ_W + 1;
    localparam int PROD_W    = 2 * OP_W;

    localparam int LIMIT_RESET = 256;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CARDIOID_EN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BULB_EN    = 2'd2;

    localparam logic signed [OP_W-1:0] ONE_Q     = OP_W'(1) << WORK_FRAC;
    localparam logic signed [OP_W-1:0] QUARTER_Q = OP_W'(1) << (WORK_FRAC - 2);
    localparam logic signed [OP_W-1:0] TWO_Q     = OP_W'(1) << (WORK_FRAC + 1);

    // 1/16 and 4 in the product format
    localparam logic signed [PROD_W-1:0] BULB_LIM = PROD_W'(1) << (2 * WORK_FRAC - 4);
    localparam logic signed [PROD_W-1:0] ESC_LIM  = PROD_W'(1) << (2 * WORK_FRAC + 2);

endpackage

// ===== rtl/met_mul.sv =====
// shared signed multiplier with registered product
module met_mul
    import met_pkg::*;
(
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [OP_W-1:0]   op_a,
    input  logic signed [OP_W-1:0]   op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = op_a * op_b;
    assign prod      = prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

endmodule

// ===== rtl/mandelbrot_escape_time_top.sv =====
// Mandelbrot escape-time unit: one point c in, its iteration count out.
// A point first passes the cardioid and bulb checks, then iterates
// z = z*z + c, with entry, exit and output steps around the loop. The loop
// ends when the limit is reached, when a part of z reaches 2, or when |z|^2
// reaches 4; an enabled cardioid or bulb hit gives an early exit. The
// single 33x33 multiplier forms zr*zr, zi*zi and zr*zi in turn for each
// iteration. One point is in work at a time; the next request is taken
// while the previous result still waits on the output.
// Configuration writes are always ready and take effect at once; write them
// only while no point is in work. Index 0 is the iteration limit, 1 enables
// the cardioid exit, 2 the period-2 bulb exit; other indexes are ignored.
module mandelbrot_escape_time_top
    import met_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int ITER_WIDTH  = ITER_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_point_real,
    input  logic signed [COORD_WIDTH-1:0] s_point_imag,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ITER_WIDTH-1:0]         m_iteration_count,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [ITER_WIDTH-1:0]         cfg_data
);

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_CA   = 12'b0000_0000_0010,
        S_CB   = 12'b0000_0000_0100,
        S_CC   = 12'b0000_0000_1000,
        S_CD   = 12'b0000_0001_0000,
        S_CE   = 12'b0000_0010_0000,
        S_CF   = 12'b0000_0100_0000,
        S_IA   = 12'b0000_1000_0000,
        S_IB   = 12'b0001_0000_0000,
        S_IC   = 12'b0010_0000_0000,
        S_ID   = 12'b0100_0000_0000,
        S_DONE = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [ITER_WIDTH-1:0] limit_reg;
    logic                  card_en_reg;
    logic                  bulb_en_reg;

    logic signed [CQ_W-1:0] cr_in;
    logic signed [CQ_W-1:0] ci_in;
    logic signed [OP_W-1:0] cr_ext;
    logic signed [OP_W-1:0] ci_ext;
    logic signed [OP_W-1:0] a_in;
    logic signed [OP_W-1:0] t_in;

    logic signed [OP_W-1:0] cr_reg, cr_next;
    logic signed [OP_W-1:0] ci_reg, ci_next;
    logic signed [OP_W-1:0] a_reg, a_next;
    logic signed [OP_W-1:0] t_reg, t_next;
    logic signed [OP_W-1:0] qf_reg, qf_next;
    logic signed [OP_W-1:0] qa_reg, qa_next;
    logic signed [OP_W-1:0] zr_reg, zr_next;
    logic signed [OP_W-1:0] zi_reg, zi_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic signed [PROD_W-1:0] ci2_reg, ci2_next;
    logic signed [PROD_W-1:0] diff_reg, diff_next;
    logic                  card_box_reg, card_box_next;
    logic                  bulb_box_reg, bulb_box_next;
    logic                  bulb_in_reg, bulb_in_next;
    logic [ITER_WIDTH-1:0] count_reg, count_next;
    logic [ITER_WIDTH-1:0] m_count_reg, m_count_next;
    logic                  m_valid_reg, m_valid_next;

    logic signed [OP_W-1:0]   mul_a;
    logic signed [OP_W-1:0]   mul_b;
    logic                     mul_en;
    logic signed [PROD_W-1:0] prod;

    logic signed [PROD_W-1:0] acc_sum;
    logic signed [PROD_W-1:0] acc_diff;
    logic signed [PROD_W-1:0] bulb_sum;
    logic signed [PROD_W-1:0] card_lhs;
    logic                     card_hit;
    logic                     z_out;

    // input scaling to q4.28: floor for wider inputs, exact shift for narrower
    generate
        if (COORD_WIDTH > CQ_W) begin : g_narrow
            assign cr_in = s_point_real[COORD_WIDTH-1 -: CQ_W];
            assign ci_in = s_point_imag[COORD_WIDTH-1 -: CQ_W];
        end else if (COORD_WIDTH < CQ_W) begin : g_widen
            assign cr_in = {s_point_real, {(CQ_W - COORD_WIDTH){1'b0}}};
            assign ci_in = {s_point_imag, {(CQ_W - COORD_WIDTH){1'b0}}};
        end else begin : g_same
            assign cr_in = s_point_real;
            assign ci_in = s_point_imag;
        end
    endgenerate

    assign cr_ext = OP_W'(cr_in);
    assign ci_ext = OP_W'(ci_in);
    assign a_in   = cr_ext - QUARTER_Q;
    assign t_in   = cr_ext + ONE_Q;

    assign s_ready           = state_reg == S_IDLE;
    assign m_valid           = m_valid_reg;
    assign m_iteration_count = m_count_reg;
    assign cfg_ready         = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg   <= ITER_WIDTH'(LIMIT_RESET);
            card_en_reg <= 1'b1;
            bulb_en_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ITER_LIMIT:  limit_reg   <= cfg_data;
                CFG_CARDIOID_EN: card_en_reg <= cfg_data[0];
                CFG_BULB_EN:     bulb_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        unique case (state_reg)
            S_CA: begin
                mul_a = a_reg;
                mul_b = a_reg;
            end
            S_CB: begin
                mul_a = ci_reg;
                mul_b = ci_reg;
            end
            S_CC: begin
                mul_a = t_reg;
                mul_b = t_reg;
            end
            S_CE: begin
                mul_a = qf_reg;
                mul_b = qa_reg;
            end
            S_IA: begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            S_IB: begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            S_IC: begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    met_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign acc_sum  = acc_reg + prod;
    assign acc_diff = acc_reg - prod;
    assign bulb_sum = prod + ci2_reg;
    assign card_lhs = prod <<< 2;
    assign card_hit = card_box_reg && (card_lhs < ci2_reg);
    assign z_out    = (zr_reg >= TWO_Q) || (zr_reg <= -TWO_Q) ||
                      (zi_reg >= TWO_Q) || (zi_reg <= -TWO_Q);

    always_comb begin
        state_next    = state_reg;
        cr_next       = cr_reg;
        ci_next       = ci_reg;
        a_next        = a_reg;
        t_next        = t_reg;
        qf_next       = qf_reg;
        qa_next       = qa_reg;
        zr_next       = zr_reg;
        zi_next       = zi_reg;
        acc_next      = acc_reg;
        ci2_next      = ci2_reg;
        diff_next     = diff_reg;
        card_box_next = card_box_reg;
        bulb_box_next = bulb_box_reg;
        bulb_in_next  = bulb_in_reg;
        count_next    = count_reg;
        m_count_next  = m_count_reg;
        m_valid_next  = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cr_next       = cr_ext;
                    ci_next       = ci_ext;
                    a_next        = a_in;
                    t_next        = t_in;
                    card_box_next = (cr_ext > -ONE_Q) && (cr_ext < ONE_Q) &&
                                    (ci_ext > -ONE_Q) && (ci_ext < ONE_Q);
                    bulb_box_next = (t_in > -ONE_Q) && (t_in < ONE_Q) &&
                                    (ci_ext > -ONE_Q) && (ci_ext < ONE_Q);
                    zr_next       = '0;
                    zi_next       = '0;
                    count_next    = '0;
                    state_next    = S_CA;
                end
            end
            S_CA: begin
                state_next = S_CB;
            end
            S_CB: begin
                acc_next   = prod;
                state_next = S_CC;
            end
            S_CC: begin
                // q = a^2 + ci^2, floored back to q.28
                ci2_next   = prod;
                qf_next    = $signed(acc_sum[WORK_FRAC +: OP_W]);
                state_next = S_CD;
            end
            S_CD: begin
                qa_next      = qf_reg + a_reg;
                bulb_in_next = bulb_box_reg && (bulb_sum < BULB_LIM);
                state_next   = S_CE;
            end
            S_CE: begin
                state_next = S_CF;
            end
            S_CF: begin
                if ((card_en_reg && card_hit) || (bulb_en_reg && bulb_in_reg)) begin
                    count_next = limit_reg;
                    state_next = S_DONE;
                end else begin
                    state_next = S_IA;
                end
            end
            S_IA: begin
                if ((count_reg >= limit_reg) || z_out) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_IB;
                end
            end
            S_IB: begin
                acc_next   = prod;
                state_next = S_IC;
            end
            S_IC: begin
                // prod holds zi^2, acc holds zr^2
                if (acc_sum >= ESC_LIM) begin
                    state_next = S_DONE;
                end else begin
                    diff_next  = acc_diff;
                    state_next = S_ID;
                end
            end
            S_ID: begin
                zr_next    = $signed(diff_reg[WORK_FRAC +: OP_W]) + cr_reg;
                zi_next    = $signed(prod[WORK_FRAC-1 +: OP_W]) + ci_reg;
                count_next = count_reg + ITER_WIDTH'(1);
                state_next = S_IA;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_count_next = count_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cr_reg       <= cr_next;
        ci_reg       <= ci_next;
        a_reg        <= a_next;
        t_reg        <= t_next;
        qf_reg       <= qf_next;
        qa_reg       <= qa_next;
        zr_reg       <= zr_next;
        zi_reg       <= zi_next;
        acc_reg      <= acc_next;
        ci2_reg      <= ci2_next;
        diff_reg     <= diff_next;
        card_box_reg <= card_box_next;
        bulb_box_reg <= bulb_box_next;
        bulb_in_reg  <= bulb_in_next;
        count_reg    <= count_next;
        m_count_reg  <= m_count_next;
    end

`ifndef ASSERT_OFF
    a_count_in_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> (count_reg <= limit_reg))
        else $error("iteration count passed the limit");

    a_z_in_box: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IB) |-> (zr_reg < TWO_Q && zr_reg > -TWO_Q &&
                                 zi_reg < TWO_Q && zi_reg > -TWO_Q))
        else $error("squaring z outside the escape box");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the done state");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_CA))
        else $error("accepted request did not start the checks");
`endif

endmodule
